// ===== src/rational_arith_reduce_defines.svh =====
// assertion macros shared by the rational reduce checker
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RAR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational reduce check failed");

// next-cycle implication, sampled on clk, off during rst
`define RAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational reduce check failed");

`endif

// ===== src/rar_pkg.sv =====
// shared types and constants of the rational reduce block
package rar_pkg;

  localparam int InW  = 16;
  localparam int MagW = 32;
  localparam int NumW = 32;
  localparam int DenW = 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // divider operand selection
  localparam logic [1:0] SEL_EUC = 2'd0;
  localparam logic [1:0] SEL_NUM = 2'd1;
  localparam logic [1:0] SEL_DEN = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       sum;
    logic       gcd_step;
    logic       g_latch;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_qn;
    logic       cap_qd;
    logic       emit;
    logic       emit_zero;
  } rar_cmd_t;

  typedef struct packed {
    logic div_done;
    logic x_zero;
    logic y_zero;
  } rar_sts_t;

endpackage

// ===== src/rational_arith_reduce.sv =====
// top level of the rational fraction arithmetic and gcd reduce block
// usage:
//   request channel: req_valid / req_stall with opcode, a_num, a_den, b_num, b_den;
//   a request is taken at a clock edge with req_valid high and req_stall low
//   result channel: res_valid / res_stall with res_num, res_den, zero_gcd_error
//   one request is worked on at a time; req_stall is high from the edge after
//   acceptance until the result has been written into the output register
//   order of work: products, then sum, then euclid remainder steps on the
//   divider (each run doubles the divisor at most 31 times before it
//   subtracts), then the gcd is picked, two exact divisions follow and the
//   output register is loaded; a zero gcd skips the divisions, and every
//   division is done by the one shared shift-subtract divider
//   a new request is taken only after the previous result is in the
//   output register
//   a finished result waits in the output register while res_stall is high;
//   the next request may already be taken and worked on meanwhile
//   reset (rst, synchronous) returns the controller to idle and drops res_valid
module rational_arith_reduce (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      opcode,
  input  logic signed [rar_pkg::InW-1:0]  a_num,
  input  logic signed [rar_pkg::InW-1:0]  a_den,
  input  logic signed [rar_pkg::InW-1:0]  b_num,
  input  logic signed [rar_pkg::InW-1:0]  b_den,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic signed [rar_pkg::NumW-1:0] res_num,
  output logic signed [rar_pkg::DenW-1:0] res_den,
  output logic                            zero_gcd_error
);
  import rar_pkg::*;

  rar_cmd_t cmd;
  rar_sts_t sts;

  // sequencing of each request
  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, euclid terms and output register
  rar_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .a_num          (a_num),
    .a_den          (a_den),
    .b_num          (b_num),
    .b_den          (b_den),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_gcd_error (zero_gcd_error)
  );

endmodule

// ===== src/rar_div.sv =====
// iterative shift-subtract magnitude divider giving quotient and remainder
module rar_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rar_pkg::MagW-1:0] a,
  input  logic [rar_pkg::MagW-1:0] b,
  output logic                     done,
  output logic [rar_pkg::MagW-1:0] q,
  output logic [rar_pkg::MagW-1:0] rem
);
  import rar_pkg::*;

  localparam int CntW = $clog2(MagW);

  logic            busy;
  logic            align;
  logic [MagW:0]   bs;
  logic [CntW-1:0] cnt;
  logic            grow;
  logic            ge;

  // divisor may double once more without passing the dividend
  assign grow = {bs, 1'b0} <= {2'b00, rem};
  assign ge   = {1'b0, rem} >= bs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      align <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        align <= 1'b1;
      end else if (busy) begin
        if (align) begin
          if (!grow) begin
            align <= 1'b0;
          end
        end else if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= a;
      bs  <= {1'b0, b};
      cnt <= '0;
      q   <= '0;
    end else if (busy) begin
      if (align) begin
        if (grow) begin
          bs  <= {bs[MagW-1:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end else begin
        if (ge) begin
          rem <= rem - bs[MagW-1:0];
        end
        q <= {q[MagW-2:0], ge};
        if (cnt != '0) begin
          bs  <= {1'b0, bs[MagW:1]};
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/rar_dp.sv =====
// datapath: operand products, euclid terms, divider and result register
module rar_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  rar_pkg::rar_cmd_t               cmd,
  output rar_pkg::rar_sts_t               sts,
  input  logic [1:0]                      opcode,
  input  logic signed [rar_pkg::InW-1:0]  a_num,
  input  logic signed [rar_pkg::InW-1:0]  a_den,
  input  logic signed [rar_pkg::InW-1:0]  b_num,
  input  logic signed [rar_pkg::InW-1:0]  b_den,
  output logic signed [rar_pkg::NumW-1:0] res_num,
  output logic signed [rar_pkg::DenW-1:0] res_den,
  output logic                            zero_gcd_error
);
  import rar_pkg::*;

  logic [1:0]            op;
  logic signed [InW-1:0] an, ad, bn, bd;
  logic signed [InW-1:0] m0b, mdb;
  logic signed [31:0]    p0, p1, pd;
  logic signed [33:0]    n_full;
  logic [MagW-1:0]       nmag, dmag, x, y, g, qn, qd;
  logic                  sgn_n, sgn_d, par, g_neg;
  logic [MagW-1:0]       div_a, div_b, div_q, div_rem;
  logic                  div_done;

  assign m0b = (op == OP_MUL) ? bn : bd;
  assign mdb = (op == OP_DIV) ? bn : bd;

  always_comb begin
    unique case (op)
      OP_ADD:  n_full = {{2{p0[31]}}, p0} + {{2{p1[31]}}, p1};
      OP_SUB:  n_full = {{2{p0[31]}}, p0} - {{2{p1[31]}}, p1};
      default: n_full = {{2{p0[31]}}, p0};
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      SEL_NUM: begin
        div_a = nmag;
        div_b = g;
      end
      SEL_DEN: begin
        div_a = dmag;
        div_b = g;
      end
      default: begin
        div_a = x;
        div_b = y;
      end
    endcase
  end

  rar_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q),
    .rem   (div_rem)
  );

  assign sts.div_done = div_done;
  assign sts.x_zero   = (x == '0);
  assign sts.y_zero   = (y == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
    if (cmd.mul) begin
      p0 <= an * m0b;
      p1 <= bn * ad;
      pd <= ad * mdb;
    end
    if (cmd.sum) begin
      sgn_n <= n_full[33];
      sgn_d <= pd[31];
      nmag  <= n_full[33] ? MagW'(-n_full) : n_full[MagW-1:0];
      dmag  <= pd[31] ? MagW'(-pd) : MagW'(pd);
      x     <= n_full[33] ? MagW'(-n_full) : n_full[MagW-1:0];
      y     <= pd[31] ? MagW'(-pd) : MagW'(pd);
      par   <= 1'b0;
    end
    if (cmd.gcd_step && div_done) begin
      x   <= y;
      y   <= div_rem;
      par <= ~par;
    end
    // euclid term signs alternate between those of the two starting terms
    if (cmd.g_latch) begin
      g     <= x;
      g_neg <= par ? sgn_d : sgn_n;
    end
    if (cmd.cap_qn) begin
      qn <= div_q;
    end
    if (cmd.cap_qd) begin
      qd <= div_q;
    end
    if (cmd.emit) begin
      if (cmd.emit_zero) begin
        res_num        <= '0;
        res_den        <= '0;
        zero_gcd_error <= 1'b1;
      end else begin
        res_num        <= (sgn_n ^ g_neg) ? NumW'(-qn) : NumW'(qn);
        res_den        <= (sgn_d ^ g_neg) ? DenW'(-qd) : qd[DenW-1:0];
        zero_gcd_error <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rar_ctrl.sv =====
// controller state machine sequencing products, euclid loop and divisions
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              res_valid,
  input  logic              res_stall,
  input  rar_pkg::rar_sts_t sts,
  output rar_pkg::rar_cmd_t cmd
);
  import rar_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_REM  = 4'd4;
  localparam logic [3:0] S_DN0  = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_DD0  = 4'd7;
  localparam logic [3:0] S_DD   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [3:0] S_EMZ  = 4'd10;

  logic [3:0] state, state_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        priority if (!sts.y_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_EUC;
          state_next    = S_REM;
        end else if (sts.x_zero) begin
          state_next = S_EMZ;
        end else begin
          cmd.g_latch = 1'b1;
          state_next  = S_DN0;
        end
      end
      S_REM: begin
        cmd.div_sel = SEL_EUC;
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_DN0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_NUM;
        state_next    = S_DN;
      end
      S_DN: begin
        cmd.div_sel = SEL_NUM;
        if (sts.div_done) begin
          cmd.cap_qn = 1'b1;
          state_next = S_DD0;
        end
      end
      S_DD0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_DEN;
        state_next    = S_DD;
      end
      S_DD: begin
        cmd.div_sel = SEL_DEN;
        if (sts.div_done) begin
          cmd.cap_qd = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMZ: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= cmd.emit | (res_valid & res_stall);
    end
  end

endmodule

// ===== src/rar_checker.sv =====
// port level checker for the rational reduce block and its bind
`include "rational_arith_reduce_defines.svh"

module rar_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            res_valid,
  input logic                            res_stall,
  input logic signed [rar_pkg::NumW-1:0] res_num,
  input logic signed [rar_pkg::DenW-1:0] res_den,
  input logic                            zero_gcd_error
);

  // zero gcd gives 0/0
  `RAR_ASSERT_IMPL(a_zero_res, res_valid && zero_gcd_error, res_num == 0 && res_den == 0)

  // a reduced result is never 0/0 without the error flag
  `RAR_ASSERT_IMPL(a_nonzero_res, res_valid && !zero_gcd_error, res_num != 0 || res_den != 0)

  // one request at a time
  `RAR_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

  // a stalled result stays offered
  `RAR_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);
